FILE: rtl/ctvs_pkg.sv
// Package for the correlated variable select block: item types, register
// indexes, widths, state codes and the saturating magnitude function.
// No dependencies.
`default_nettype none

package ctvs_pkg;

   // Fixed field widths
   localparam int CORR_BITS     = 16;
   localparam int SCORE_BITS    = CORR_BITS - 1;
   localparam int MAX_VARS      = 64;
   localparam int VAR_BITS      = 6;
   localparam int IDX_BITS      = 7;
   localparam int NV_BITS       = 7;
   localparam int PC_BITS       = 5;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 7;

   // Register indexes and reset values
   localparam logic [CSR_IDX_BITS-1:0] CSR_NUM_VARS   = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PICK_COUNT = 1'd1;
   localparam logic [NV_BITS-1:0]      NUM_VARS_RST   = 7'd64;
   localparam logic [PC_BITS-1:0]      PICK_COUNT_RST = 5'd1;

   // Item function codes
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SELECT = 1'b1;

   typedef struct packed {
      logic                        func;
      logic [VAR_BITS-1:0]         row_index;
      logic [VAR_BITS-1:0]         col_index;
      logic signed [CORR_BITS-1:0] corr_value;
      logic [MAX_VARS-1:0]         observed_mask;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] var_index;
      logic                is_last;
      logic                error;
   } rsp_type;

   // Read-side pipeline stage: one entry returning from a memory
   typedef struct packed {
      logic                vld;
      logic                pick;
      logic                hit;
      logic                last;
      logic [VAR_BITS-1:0] idx;
   } stage_type;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_SCORE     = 7'b0000010,
      ST_SCORE_END = 7'b0000100,
      ST_SCAN      = 7'b0001000,
      ST_SCAN_END  = 7'b0010000,
      ST_PICK      = 7'b0100000,
      ST_EMIT      = 7'b1000000
   } state_type;

   // Absolute value, most negative code saturates to the largest positive
   function automatic logic [SCORE_BITS-1:0] magnitude(input logic [CORR_BITS-1:0] v);
      logic [CORR_BITS-1:0] neg;
      neg = ~v + 1'b1;
      if (!v[CORR_BITS-1]) begin
         return v[SCORE_BITS-1:0];
      end else if (neg[CORR_BITS-1]) begin
         return '1;
      end else begin
         return neg[SCORE_BITS-1:0];
      end
   endfunction

endpackage

`default_nettype wire

FILE: rtl/top_correlated_variable_select.sv
// Top level of the correlated variable select block: sequencer, score scan,
// sorted pick list and output register. Uses ctvs_pkg and ctvs_ram.
`default_nettype none

// Usage:
//   Input items enter on start/busy/req_item; an item is taken when start is
//   high and busy is low. A write item (func 0) stores one correlation entry
//   in the 4096-entry matrix memory and gives no result; busy
//   stays low. A select item (func 1) runs the selection while busy is high.
//   Results leave on rsp_strobe/rsp_item, one per cycle, one cycle each; the
//   receiver cannot stall them. The last result of a selection has is_last.
//   An empty observed set gives one error result the cycle after the item,
//   with no busy time. Else, with pick_count zero, a select item gives no result.
//   Select steps, nv = min(num_vars,64), np = min(pick_count,MAX_PICK): a
//   score pass over nv*nv matrix entries (one matrix memory read per cycle),
//   np pick passes over nv scores (one score memory read per cycle), then
//   np results.
//   Registers are written on csr_valid/csr_ready; ready is high while idle.
//   Reset (synchronous) returns to idle with num_vars 64 and pick_count 1;
//   memory contents are not cleared and need no clearing pass.
module top_correlated_variable_select #(
   parameter int MAX_PICK = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire ctvs_pkg::req_type                   req_item,
   output logic                                     rsp_strobe,
   output ctvs_pkg::rsp_type                        rsp_item,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ctvs_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [ctvs_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int PICK_CW = $clog2(MAX_PICK + 1);
   localparam int PIDX_W  = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
   localparam int VB      = ctvs_pkg::VAR_BITS;
   localparam int SB      = ctvs_pkg::SCORE_BITS;
   localparam int IB      = ctvs_pkg::IDX_BITS;

   ctvs_pkg::state_type              state_ff, state_in;
   logic [ctvs_pkg::NV_BITS-1:0]     num_vars_ff;
   logic [ctvs_pkg::PC_BITS-1:0]     pick_count_ff;
   logic [ctvs_pkg::MAX_VARS-1:0]    mask_ff, mask_in;
   logic [VB-1:0]                    nvl_ff, nvl_in;
   logic [PICK_CW-1:0]               np_ff, np_in;
   logic [VB-1:0]                    row_ff, row_in;
   logic [VB-1:0]                    col_ff, col_in;
   ctvs_pkg::stage_type              stage_ff, stage_in;
   logic [SB-1:0]                    best_ff, best_in;
   logic [VB-1:0]                    sel_ff, sel_in;
   logic                             sel_vld_ff, sel_vld_in;
   logic [PICK_CW-1:0]               k_ff, k_in;
   logic [IB-1:0]                    list_ff [MAX_PICK];
   logic [IB-1:0]                    list_in [MAX_PICK];
   logic [IB-1:0]                    ins_list [MAX_PICK];
   logic                             rsp_strobe_ff, rsp_strobe_in;
   ctvs_pkg::rsp_type                rsp_ff, rsp_in;

   logic                             accept;
   logic [ctvs_pkg::NV_BITS-1:0]     nv_sat;
   logic [PICK_CW-1:0]               np_sat;
   logic [ctvs_pkg::MAX_VARS-1:0]    in_use;
   logic [ctvs_pkg::MAX_VARS-1:0]    sel_mask;
   logic                             any_obs;
   logic [ctvs_pkg::CORR_BITS-1:0]   corr_rdata;
   logic [SB-1:0]                    score_rdata;
   logic [SB-1:0]                    mag;
   logic [SB-1:0]                    cand;
   logic                             corr_we;
   logic                             score_we;
   logic [VB-1:0]                    score_waddr;
   logic [SB-1:0]                    score_wdata;
   logic [IB-1:0]                    ins_val;

   assign busy      = (state_ff != ctvs_pkg::ST_IDLE);
   assign csr_ready = (state_ff == ctvs_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign corr_we   = accept && (req_item.func == ctvs_pkg::FUNC_WRITE);

   // Saturate the register values
   assign nv_sat = (num_vars_ff > ctvs_pkg::NV_BITS'(ctvs_pkg::MAX_VARS))
                 ? ctvs_pkg::NV_BITS'(ctvs_pkg::MAX_VARS) : num_vars_ff;
   assign np_sat = (32'(pick_count_ff) > MAX_PICK)
                 ? PICK_CW'(MAX_PICK) : PICK_CW'(pick_count_ff);

   // Keep only observed variables that are in use
   always_comb begin
      for (int b = 0; b < ctvs_pkg::MAX_VARS; b++) begin
         in_use[b] = (ctvs_pkg::NV_BITS'(b) < nv_sat);
      end
   end
   assign sel_mask = req_item.observed_mask & in_use;
   assign any_obs  = |sel_mask;

   // Matrix memory, address {row, col}
   ctvs_ram #(
      .WIDTH (ctvs_pkg::CORR_BITS),
      .DEPTH (ctvs_pkg::MAX_VARS * ctvs_pkg::MAX_VARS)
   ) u_corr_ram (
      .clock (clock),
      .we    (corr_we),
      .waddr ({req_item.row_index, req_item.col_index}),
      .wdata (req_item.corr_value),
      .raddr ({row_ff, col_ff}),
      .rdata (corr_rdata)
   );

   // Column score memory
   ctvs_ram #(
      .WIDTH (SB),
      .DEPTH (ctvs_pkg::MAX_VARS)
   ) u_score_ram (
      .clock (clock),
      .we    (score_we),
      .waddr (score_waddr),
      .wdata (score_wdata),
      .raddr (col_ff),
      .rdata (score_rdata)
   );

   assign mag  = ctvs_pkg::magnitude(corr_rdata);
   assign cand = (stage_ff.hit && (mag > best_ff)) ? mag : best_ff;

   // Insert the picked index into the sorted list, after equal entries
   assign ins_val = IB'(sel_ff) + IB'(1);
   always_comb begin
      logic          gt;
      logic          prev_gt;
      logic [IB-1:0] prev_val;
      prev_gt  = 1'b0;
      prev_val = '0;
      for (int p = 0; p < MAX_PICK; p++) begin
         gt = (PICK_CW'(p) < k_ff) && (list_ff[p] > ins_val);
         if (prev_gt) begin
            ins_list[p] = prev_val;
         end else if (gt || (PICK_CW'(p) == k_ff)) begin
            ins_list[p] = ins_val;
         end else begin
            ins_list[p] = list_ff[p];
         end
         prev_gt  = gt;
         prev_val = list_ff[p];
      end
   end

   // Sequencer and read-side processing
   always_comb begin
      state_in      = state_ff;
      mask_in       = mask_ff;
      nvl_in        = nvl_ff;
      np_in         = np_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      stage_in      = '0;
      best_in       = best_ff;
      sel_in        = sel_ff;
      sel_vld_in    = sel_vld_ff;
      k_in          = k_ff;
      list_in       = list_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      score_we      = 1'b0;
      score_waddr   = stage_ff.idx;
      score_wdata   = cand;

      // Fold a returning matrix entry into the column maximum
      if (stage_ff.vld && !stage_ff.pick) begin
         if (stage_ff.last) begin
            score_we = 1'b1;
            best_in  = '0;
         end else begin
            best_in = cand;
         end
      end

      // Track the earliest largest score in a pick pass
      if (stage_ff.vld && stage_ff.pick && stage_ff.hit &&
          (!sel_vld_ff || (score_rdata > best_ff))) begin
         best_in    = score_rdata;
         sel_in     = stage_ff.idx;
         sel_vld_in = 1'b1;
      end

      case (state_ff)
         ctvs_pkg::ST_IDLE: begin
            if (accept && (req_item.func == ctvs_pkg::FUNC_SELECT)) begin
               mask_in = sel_mask;
               nvl_in  = VB'(nv_sat - ctvs_pkg::NV_BITS'(1));
               np_in   = np_sat;
               row_in  = '0;
               col_in  = '0;
               best_in = '0;
               if (!any_obs) begin
                  rsp_strobe_in    = 1'b1;
                  rsp_in.var_index = '0;
                  rsp_in.is_last   = 1'b1;
                  rsp_in.error     = 1'b1;
               end else if (np_sat != '0) begin
                  state_in = ctvs_pkg::ST_SCORE;
               end
            end
         end
         ctvs_pkg::ST_SCORE: begin
            stage_in.vld  = 1'b1;
            stage_in.pick = 1'b0;
            stage_in.hit  = mask_ff[col_ff] && !mask_ff[row_ff];
            stage_in.last = (row_ff == nvl_ff);
            stage_in.idx  = col_ff;
            if (row_ff == nvl_ff) begin
               row_in = '0;
               col_in = col_ff + VB'(1);
               if (col_ff == nvl_ff) begin
                  state_in = ctvs_pkg::ST_SCORE_END;
               end
            end else begin
               row_in = row_ff + VB'(1);
            end
         end
         ctvs_pkg::ST_SCORE_END: begin
            col_in     = '0;
            sel_vld_in = 1'b0;
            k_in       = '0;
            state_in   = ctvs_pkg::ST_SCAN;
         end
         ctvs_pkg::ST_SCAN: begin
            stage_in.vld  = 1'b1;
            stage_in.pick = 1'b1;
            stage_in.hit  = mask_ff[col_ff];
            stage_in.last = (col_ff == nvl_ff);
            stage_in.idx  = col_ff;
            col_in        = col_ff + VB'(1);
            if (col_ff == nvl_ff) begin
               state_in = ctvs_pkg::ST_SCAN_END;
            end
         end
         ctvs_pkg::ST_SCAN_END: begin
            state_in = ctvs_pkg::ST_PICK;
         end
         ctvs_pkg::ST_PICK: begin
            // Drop the picked score and record the pick
            score_we    = 1'b1;
            score_waddr = sel_ff;
            score_wdata = '0;
            list_in     = ins_list;
            best_in     = '0;
            sel_vld_in  = 1'b0;
            col_in      = '0;
            if ((k_ff + PICK_CW'(1)) == np_ff) begin
               k_in     = '0;
               state_in = ctvs_pkg::ST_EMIT;
            end else begin
               k_in     = k_ff + PICK_CW'(1);
               state_in = ctvs_pkg::ST_SCAN;
            end
         end
         ctvs_pkg::ST_EMIT: begin
            rsp_strobe_in    = 1'b1;
            rsp_in.var_index = list_ff[k_ff[PIDX_W-1:0]];
            rsp_in.is_last   = ((k_ff + PICK_CW'(1)) == np_ff);
            rsp_in.error     = 1'b0;
            k_in             = k_ff + PICK_CW'(1);
            if ((k_ff + PICK_CW'(1)) == np_ff) begin
               state_in = ctvs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ctvs_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ctvs_pkg::ST_IDLE;
         stage_ff      <= '0;
         sel_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         num_vars_ff   <= ctvs_pkg::NUM_VARS_RST;
         pick_count_ff <= ctvs_pkg::PICK_COUNT_RST;
      end else begin
         state_ff      <= state_in;
         stage_ff      <= stage_in;
         sel_vld_ff    <= sel_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ctvs_pkg::CSR_NUM_VARS: begin
                  num_vars_ff <= csr_wdata[ctvs_pkg::NV_BITS-1:0];
               end
               ctvs_pkg::CSR_PICK_COUNT: begin
                  pick_count_ff <= csr_wdata[ctvs_pkg::PC_BITS-1:0];
               end
               default: begin
                  num_vars_ff <= num_vars_ff;
               end
            endcase
         end
      end
   end

   // Payload and counter registers
   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      nvl_ff  <= nvl_in;
      np_ff   <= np_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      best_ff <= best_in;
      sel_ff  <= sel_in;
      k_ff    <= k_in;
      list_ff <= list_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef SYNTH
   // A normal result only follows an emit cycle
   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_ff.error |-> $past(state_ff == ctvs_pkg::ST_EMIT))
      else $error("result strobe outside emit");

   // Emitted indices are always 1-based
   a_emit_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ctvs_pkg::ST_EMIT |=> rsp_ff.var_index != '0)
      else $error("emitted index is zero");

   // A pick always has a selected variable
   a_pick_has_sel: assert property (@(posedge clock) disable iff (reset)
      state_ff == ctvs_pkg::ST_PICK |-> sel_vld_ff)
      else $error("pick without selection");

   // Returning reads only during the score and scan passes
   a_stage_in_pass: assert property (@(posedge clock) disable iff (reset)
      stage_ff.vld |-> (state_ff == ctvs_pkg::ST_SCORE ||
                        state_ff == ctvs_pkg::ST_SCORE_END ||
                        state_ff == ctvs_pkg::ST_SCAN ||
                        state_ff == ctvs_pkg::ST_SCAN_END))
      else $error("read data outside a pass");
`endif

endmodule

`default_nettype wire

FILE: rtl/ctvs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module ctvs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: verif/top_correlated_variable_select_tb.sv
// Testbench for top_correlated_variable_select: directed and random write and
// select items, every result checked against an in-bench selection model.
// Depends on ctvs_pkg and the top_correlated_variable_select RTL.
module top_correlated_variable_select_tb;

   localparam int PICK_LIMIT   = 16;
   localparam int RANDOM_ITEMS = 140;
   localparam int CALM_TAIL    = 20;
   localparam int QUIET_LIMIT  = 50000;
   localparam int REQ_BITS     = $bits(ctvs_pkg::req_type);

   typedef enum logic [1:0] {STEP_ITEM, STEP_CSR, STEP_SETTLE} step_kind_type;

   typedef struct {
      step_kind_type                          kind;
      ctvs_pkg::req_type                      item;
      logic [ctvs_pkg::CSR_IDX_BITS-1:0]      reg_index;
      logic [ctvs_pkg::CSR_DATA_BITS-1:0]     reg_value;
      int                                     settle_cycles;
      bit                                     calm;
   } plan_step_type;

   // Block ports
   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 start = 1'b0;
   logic                                 busy;
   ctvs_pkg::req_type                    req_item = '0;
   logic                                 rsp_strobe;
   ctvs_pkg::rsp_type                    rsp_item;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [ctvs_pkg::CSR_IDX_BITS-1:0]    csr_index = '0;
   logic [ctvs_pkg::CSR_DATA_BITS-1:0]   csr_wdata = '0;

   // Selection model state
   logic signed [ctvs_pkg::CORR_BITS-1:0]
                         corr_mem [0:ctvs_pkg::MAX_VARS*ctvs_pkg::MAX_VARS-1];
   logic [ctvs_pkg::NV_BITS-1:0] model_num_vars = ctvs_pkg::NUM_VARS_RST;
   logic [ctvs_pkg::PC_BITS-1:0] model_pick_count = ctvs_pkg::PICK_COUNT_RST;
   ctvs_pkg::rsp_type            picks_expected [$];

   // Stimulus plan and its view of the settings
   plan_step_type                pending_steps [$];
   bit                           written [0:ctvs_pkg::MAX_VARS*ctvs_pkg::MAX_VARS-1];
   logic [ctvs_pkg::NV_BITS-1:0] gen_num_vars = ctvs_pkg::NUM_VARS_RST;
   logic [ctvs_pkg::PC_BITS-1:0] gen_pick_count = ctvs_pkg::PICK_COUNT_RST;
   int                           gen_items = 0;
   bit                           calm_mode = 1'b0;

   // Handshake bookkeeping
   logic                        took_item = 1'b0;
   logic                        took_csr = 1'b0;
   int                          idle_left = 0;
   int                          settle_left = 0;
   bit                          settling = 1'b0;
   int                          quiet_cycles = 0;
   int                          fail_count = 0;

   top_correlated_variable_select #(.MAX_PICK(PICK_LIMIT)) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Store a write item, or score, pick and sort for a select item
   function automatic void predict_selection(input ctvs_pkg::req_type it);
      int                nv, np, nobs, sel, p, v;
      int                score [ctvs_pkg::MAX_VARS];
      int                order [PICK_LIMIT];
      ctvs_pkg::rsp_type r;
      if (it.func == ctvs_pkg::FUNC_WRITE) begin
         corr_mem[{it.row_index, it.col_index}] = it.corr_value;
         return;
      end
      nv = (model_num_vars > ctvs_pkg::MAX_VARS) ? ctvs_pkg::MAX_VARS : model_num_vars;
      np = (model_pick_count > PICK_LIMIT) ? PICK_LIMIT : model_pick_count;
      nobs = 0;
      // score each observed column by its strongest link to a missing row
      for (int j = 0; j < nv; j++) begin
         score[j] = 0;
         if (it.observed_mask[j]) begin
            nobs++;
            for (int i = 0; i < nv; i++) begin
               if (!it.observed_mask[i]) begin
                  v = corr_mem[i * ctvs_pkg::MAX_VARS + j];
                  if (v < 0) v = -v;
                  if (v > (1 << ctvs_pkg::SCORE_BITS) - 1) begin
                     v = (1 << ctvs_pkg::SCORE_BITS) - 1;
                  end
                  if (v > score[j]) score[j] = v;
               end
            end
         end
      end
      if (nobs == 0) begin
         r.var_index = '0;
         r.is_last = 1'b1;
         r.error = 1'b1;
         picks_expected = {picks_expected, r};
         return;
      end
      // take the earliest top score, clear it, keep the list sorted
      for (int k = 0; k < np; k++) begin
         sel = -1;
         for (int j = 0; j < nv; j++) begin
            if (it.observed_mask[j] && (sel < 0 || score[j] > score[sel])) sel = j;
         end
         score[sel] = 0;
         p = k;
         while (p > 0 && order[p-1] > sel + 1) begin
            order[p] = order[p-1];
            p--;
         end
         order[p] = sel + 1;
      end
      for (int k = 0; k < np; k++) begin
         r.var_index = ctvs_pkg::IDX_BITS'(order[k]);
         r.is_last = (k == np - 1);
         r.error = 1'b0;
         picks_expected = {picks_expected, r};
      end
   endfunction

   function automatic void check_field(input string field,
                                       input logic [ctvs_pkg::IDX_BITS-1:0] want,
                                       input logic [ctvs_pkg::IDX_BITS-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   // Sample handshakes, advance the model, check results
   always @(posedge clock) begin
      ctvs_pkg::rsp_type want;
      if (reset) begin
         took_item <= 1'b0;
         took_csr <= 1'b0;
         quiet_cycles <= quiet_cycles + 1;
         model_num_vars = ctvs_pkg::NUM_VARS_RST;
         model_pick_count = ctvs_pkg::PICK_COUNT_RST;
      end else begin
         took_item <= start && !busy;
         took_csr <= csr_valid && csr_ready;
         if (start && !busy) predict_selection(req_item);
         if (csr_valid && csr_ready) begin
            if (csr_index == ctvs_pkg::CSR_NUM_VARS) begin
               model_num_vars = csr_wdata;
            end else begin
               model_pick_count = csr_wdata[ctvs_pkg::PC_BITS-1:0];
            end
         end
         if (rsp_strobe) begin
            if (picks_expected.size() == 0) begin
               $error("result with none expected: var_index %0d is_last %0b error %0b",
                      rsp_item.var_index, rsp_item.is_last, rsp_item.error);
               fail_count++;
            end else begin
               want = picks_expected.pop_front();
               check_field("var_index", want.var_index, rsp_item.var_index);
               check_field("is_last", ctvs_pkg::IDX_BITS'(want.is_last),
                           ctvs_pkg::IDX_BITS'(rsp_item.is_last));
               check_field("error", ctvs_pkg::IDX_BITS'(want.error),
                           ctvs_pkg::IDX_BITS'(rsp_item.error));
            end
         end
         if ((start && !busy) || (csr_valid && csr_ready) || rsp_strobe) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Drive the next planned step at the falling edge
   always @(negedge clock) begin
      logic                                next_start, next_valid, holding;
      ctvs_pkg::req_type                   next_req;
      logic [ctvs_pkg::CSR_IDX_BITS-1:0]   next_index;
      logic [ctvs_pkg::CSR_DATA_BITS-1:0]  next_data;
      if (!reset) begin
         if (took_item || took_csr) pending_steps.delete(0);
         next_start = 1'b0;
         next_valid = 1'b0;
         next_req = REQ_BITS'({$urandom, $urandom, $urandom});
         next_index = ctvs_pkg::CSR_IDX_BITS'($urandom);
         next_data = ctvs_pkg::CSR_DATA_BITS'($urandom);
         if (pending_steps.size() > 0) begin
            case (pending_steps[0].kind)
               STEP_ITEM: begin
                  holding = start && !took_item;
                  if (!holding && idle_left == 0 && !pending_steps[0].calm &&
                      $urandom_range(3) == 0) begin
                     idle_left = $urandom_range(9, 1);
                  end
                  if (!holding && idle_left > 0) begin
                     idle_left--;
                  end else begin
                     next_start = 1'b1;
                     next_req = pending_steps[0].item;
                  end
               end
               STEP_CSR: begin
                  next_valid = 1'b1;
                  next_index = pending_steps[0].reg_index;
                  next_data = pending_steps[0].reg_value;
               end
               STEP_SETTLE: begin
                  // wait out every result, then the block's own latency
                  if (!settling) begin
                     if (picks_expected.size() == 0) begin
                        settling = 1'b1;
                        settle_left = pending_steps[0].settle_cycles;
                     end
                  end else if (settle_left > 0) begin
                     settle_left--;
                  end else begin
                     settling = 1'b0;
                     pending_steps.delete(0);
                  end
               end
               default: begin
               end
            endcase
         end
         start <= next_start;
         req_item <= next_req;
         csr_valid <= next_valid;
         csr_index <= next_index;
         csr_wdata <= next_data;
      end
   end

   function automatic void add_step(input step_kind_type kind, input ctvs_pkg::req_type it,
                                    input logic [ctvs_pkg::CSR_IDX_BITS-1:0] idx,
                                    input logic [ctvs_pkg::CSR_DATA_BITS-1:0] val,
                                    input int cycles);
      plan_step_type s;
      s.kind = kind;
      s.item = it;
      s.reg_index = idx;
      s.reg_value = val;
      s.settle_cycles = cycles;
      s.calm = calm_mode;
      pending_steps = {pending_steps, s};
      if (kind == STEP_ITEM) gen_items++;
   endfunction

   // Worst-case select time at the planned settings, with margin
   function automatic int pause_cycles();
      int nv, np;
      nv = (gen_num_vars > ctvs_pkg::MAX_VARS) ? ctvs_pkg::MAX_VARS : gen_num_vars;
      np = (gen_pick_count > PICK_LIMIT) ? PICK_LIMIT : gen_pick_count;
      return nv * nv + np * (nv + 4) + 16;
   endfunction

   function automatic logic [ctvs_pkg::CORR_BITS-1:0] draw_corr();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h8001;
         3: return 16'h0000;
         default: return ctvs_pkg::CORR_BITS'($urandom);
      endcase
   endfunction

   function automatic void plan_write(input int row, input int col,
                                      input logic [ctvs_pkg::CORR_BITS-1:0] val);
      ctvs_pkg::req_type it;
      it = REQ_BITS'({$urandom, $urandom, $urandom});
      it.func = ctvs_pkg::FUNC_WRITE;
      it.row_index = ctvs_pkg::VAR_BITS'(row);
      it.col_index = ctvs_pkg::VAR_BITS'(col);
      it.corr_value = val;
      written[row * ctvs_pkg::MAX_VARS + col] = 1'b1;
      add_step(STEP_ITEM, it, '0, '0, 0);
   endfunction

   // Fill every entry the select scores from, optionally refresh some, then select
   function automatic void plan_select(input logic [ctvs_pkg::MAX_VARS-1:0] mask,
                                       input bit refresh);
      int                nv;
      ctvs_pkg::req_type it;
      nv = (gen_num_vars > ctvs_pkg::MAX_VARS) ? ctvs_pkg::MAX_VARS : gen_num_vars;
      for (int i = 0; i < nv; i++) begin
         for (int j = 0; j < nv; j++) begin
            if (!mask[i] && mask[j] && (!written[i * ctvs_pkg::MAX_VARS + j] ||
                (refresh && nv <= 16 && $urandom_range(3) == 0))) begin
               plan_write(i, j, draw_corr());
            end
         end
      end
      it = REQ_BITS'({$urandom, $urandom, $urandom});
      it.func = ctvs_pkg::FUNC_SELECT;
      it.observed_mask = mask;
      add_step(STEP_ITEM, it, '0, '0, 0);
   endfunction

   function automatic void plan_config(input logic [ctvs_pkg::CSR_IDX_BITS-1:0] idx,
                                       input logic [ctvs_pkg::CSR_DATA_BITS-1:0] val);
      add_step(STEP_SETTLE, '0, '0, '0, pause_cycles());
      add_step(STEP_CSR, '0, idx, val, 0);
      if (idx == ctvs_pkg::CSR_NUM_VARS) begin
         gen_num_vars = val;
      end else begin
         gen_pick_count = val[ctvs_pkg::PC_BITS-1:0];
      end
   endfunction

   initial begin
      logic [ctvs_pkg::NV_BITS-1:0]       nv_val;
      logic [ctvs_pkg::CSR_DATA_BITS-1:0] pick_val;
      logic [ctvs_pkg::MAX_VARS-1:0]      mask, low_bits;
      int                                 eff, nsel;
      bit                                 big;

      // nothing missing: all scores zero, the earliest variable wins
      plan_select('1, 1'b0);
      // empty observed set
      plan_select('0, 1'b0);
      // saturated magnitudes tie; ties go to the earliest, repeats allowed
      plan_config(ctvs_pkg::CSR_NUM_VARS, 7'd4);
      plan_config(ctvs_pkg::CSR_PICK_COUNT, 7'd3);
      plan_write(1, 0, 16'h8000);
      plan_write(3, 0, 16'h7FFF);
      plan_write(1, 2, 16'h8001);
      plan_write(3, 2, 16'h0064);
      plan_select(64'hFFFF_FFFF_FFFF_FFF5, 1'b0);
      // no picks: silent select, but an empty set still flags
      plan_config(ctvs_pkg::CSR_PICK_COUNT, 7'd0);
      plan_select(64'h0000_0000_0000_0005, 1'b0);
      plan_select(64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
      // no variable in use
      plan_config(ctvs_pkg::CSR_NUM_VARS, 7'd0);
      plan_config(ctvs_pkg::CSR_PICK_COUNT, 7'd16);
      plan_select('1, 1'b0);
      // one variable picked sixteen times, then hidden by the mask
      plan_config(ctvs_pkg::CSR_NUM_VARS, 7'd1);
      plan_select(64'h0000_0000_0000_0001, 1'b0);
      plan_select(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
      // both registers above their limits
      plan_config(ctvs_pkg::CSR_NUM_VARS, 7'd127);
      plan_config(ctvs_pkg::CSR_PICK_COUNT, 7'h7F);
      plan_select('1, 1'b0);

      // random phases of settings, each with a run of selects
      gen_items = 0;
      while (gen_items < RANDOM_ITEMS) begin
         calm_mode = (gen_items >= RANDOM_ITEMS - CALM_TAIL);
         case ($urandom_range(9))
            0: nv_val = ctvs_pkg::NV_BITS'($urandom_range(127, 64));
            1: nv_val = ctvs_pkg::NV_BITS'($urandom_range(1));
            default: nv_val = ctvs_pkg::NV_BITS'($urandom_range(10, 2));
         endcase
         pick_val = ctvs_pkg::CSR_DATA_BITS'($urandom_range(PICK_LIMIT));
         if ($urandom_range(3) == 0) begin
            pick_val = ctvs_pkg::CSR_DATA_BITS'($urandom_range(127));
         end
         if ($urandom_range(1) == 0) begin
            plan_config(ctvs_pkg::CSR_NUM_VARS, nv_val);
            plan_config(ctvs_pkg::CSR_PICK_COUNT, pick_val);
         end else begin
            plan_config(ctvs_pkg::CSR_PICK_COUNT, pick_val);
            plan_config(ctvs_pkg::CSR_NUM_VARS, nv_val);
         end
         eff = (nv_val > ctvs_pkg::MAX_VARS) ? ctvs_pkg::MAX_VARS : nv_val;
         big = (eff >= ctvs_pkg::MAX_VARS);
         low_bits = big ? '1 : ((64'd1 << eff) - 64'd1);
         nsel = big ? 2 : $urandom_range(8, 3);
         for (int n = 0; n < nsel; n++) begin
            if ($urandom_range(2) == 0) begin
               plan_write($urandom_range(63), $urandom_range(63), draw_corr());
            end
            if (big) begin
               // keep the missing rows to one variable so few fills are needed
               mask = '1;
               if ($urandom_range(1) == 0) mask[63] = 1'b0;
            end else begin
               mask = {$urandom, $urandom};
               case ($urandom_range(7))
                  0: mask = mask & ~low_bits;
                  1: mask = mask | low_bits;
                  default: begin
                  end
               endcase
            end
            plan_select(mask, 1'b1);
         end
      end
      add_step(STEP_SETTLE, '0, '0, '0, pause_cycles());

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      wait (pending_steps.size() == 0);
      if (fail_count == 0 && picks_expected.size() == 0) begin
         $display("top_correlated_variable_select verification clean");
      end else begin
         $display("top_correlated_variable_select verification failed");
      end
      $finish;
   end

   // Stop a run that has stopped making progress
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("top_correlated_variable_select verification failed");
      $finish;
   end

endmodule
